[rtl/core/slcan_lrp_pkg.sv]
// Shared types, character codes and line positions for the slcan line receive parser.
package slcan_lrp_pkg;

    // compare width for line positions and lengths (positions stay below 256)
    localparam int CMP_W = 9;

    // characters of interest
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_BELL = 8'h07;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_8    = 8'h38;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_F    = 8'h46;
    localparam logic [7:0] CH_T    = 8'h54;
    localparam logic [7:0] CH_Z    = 8'h5A;

    // field positions within a line
    localparam logic [CMP_W-1:0] POS_LEAD       = 9'd0;
    localparam logic [CMP_W-1:0] POS_STATUS_HI  = 9'd1;
    localparam logic [CMP_W-1:0] POS_STATUS_LO  = 9'd2;
    localparam logic [CMP_W-1:0] POS_ID_LAST    = 9'd8;
    localparam logic [CMP_W-1:0] POS_DLC        = 9'd9;
    localparam logic [CMP_W-1:0] POS_DATA       = 9'd10;
    localparam logic [CMP_W-1:0] POS_DATA_END   = 9'd26;
    localparam logic [CMP_W-1:0] STATUS_MIN_LEN = 9'd3;

    localparam int DATA_BYTES = 8;
    localparam int TDATA_W    = 104;

    typedef enum logic [2:0] {
        KIND_FRAME     = 3'd0,
        KIND_MALFORMED = 3'd1,
        KIND_STATUS    = 3'd2,
        KIND_ACK       = 3'd3,
        KIND_ZREPLY    = 3'd4,
        KIND_BELL_ERR  = 3'd5,
        KIND_OTHER     = 3'd6,
        KIND_OVERFLOW  = 3'd7
    } t_line_kind;

    // line state as it stands after the current byte has been folded in
    typedef struct packed {
        logic [7:0]  lead_char;
        logic [31:0] id_accum;
        logic [7:0]  length_char;
        logic [63:0] data_accum;
        logic [6:0]  status_accum;
    } t_line_snap;

    typedef struct packed {
        t_line_kind  line_kind;
        logic [2:0]  priority_res;
        logic        data_page;
        logic [7:0]  pdu_format;
        logic [7:0]  pdu_specific;
        logic [7:0]  source_address;
        logic [3:0]  data_length;
        logic [63:0] payload;
        logic [6:0]  status_code;
    } t_result;

endpackage

[rtl/core/slcan_lrp_line_state.sv]
// Per-line state registers and the per-byte field accumulation.
module slcan_lrp_line_state
    import slcan_lrp_pkg::*;
#(
    parameter int POS_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,     // a non-NUL byte is processed this cycle
    input  logic             i_clear,    // line completes with this byte
    input  logic [7:0]       i_byte,
    output t_line_snap       o_snap,
    output logic [POS_W-1:0] o_pos_next
);

    logic [POS_W-1:0] r_pos;
    logic [7:0]       r_lead, n_lead;
    logic [31:0]      r_id, n_id;
    logic             r_id_stop, n_id_stop;
    logic [7:0]       r_len_char, n_len_char;
    logic [63:0]      r_data, n_data;
    logic [7:0]       r_marks, n_marks;
    logic [6:0]       r_status, n_status;

    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] data_off;
    logic [2:0]       lane;
    logic             hex_ok;
    logic [3:0]       hex_val;
    logic [3:0]       dec_val;
    logic [7:0]       lane_old;

    assign pos_x    = CMP_W'(r_pos);
    assign data_off = pos_x - POS_DATA;
    assign lane     = data_off[3:1];
    assign lane_old = r_data[lane*8 +: 8];

    // hex digit decode
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = i_byte[3:0];
        if (i_byte >= CH_0 && i_byte <= CH_9) begin
            hex_val = i_byte[3:0];
        end else if ((i_byte >= 8'h41 && i_byte <= 8'h46) ||
                     (i_byte >= 8'h61 && i_byte <= 8'h66)) begin
            hex_val = i_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign dec_val = (i_byte >= CH_0 && i_byte <= CH_9) ? i_byte[3:0] : 4'd0;

    always_comb begin
        n_lead     = r_lead;
        n_id       = r_id;
        n_id_stop  = r_id_stop;
        n_len_char = r_len_char;
        n_data     = r_data;
        n_marks    = r_marks;
        n_status   = r_status;

        if (pos_x == POS_LEAD) begin
            n_lead = i_byte;
        end else if (pos_x <= POS_ID_LAST) begin
            if (!r_id_stop && hex_ok) begin
                n_id = {r_id[27:0], hex_val};
            end else begin
                n_id_stop = 1'b1;
            end
        end else if (pos_x == POS_DLC) begin
            n_len_char = i_byte;
        end else if (pos_x < POS_DATA_END) begin
            if (!r_marks[lane] && hex_ok) begin
                for (int i = 0; i < DATA_BYTES; i++) begin
                    if (lane == 3'(i)) begin
                        n_data[i*8 +: 8] = {lane_old[3:0], hex_val};
                    end
                end
            end else begin
                n_marks[lane] = 1'b1;
            end
        end

        if (pos_x == POS_STATUS_HI) begin
            n_status = 7'(dec_val);
        end else if (pos_x == POS_STATUS_LO) begin
            // times ten as shift-add; value stays below 100
            n_status = 7'({r_status, 3'b000} + {r_status, 1'b0} + 10'(dec_val));
        end
    end

    assign o_snap.lead_char    = n_lead;
    assign o_snap.id_accum     = n_id;
    assign o_snap.length_char  = n_len_char;
    assign o_snap.data_accum   = n_data;
    assign o_snap.status_accum = n_status;
    assign o_pos_next          = r_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_clear)) begin
            r_pos      <= '0;
            r_lead     <= '0;
            r_id       <= '0;
            r_id_stop  <= 1'b0;
            r_len_char <= '0;
            r_data     <= '0;
            r_marks    <= '0;
            r_status   <= '0;
        end else if (i_take) begin
            r_pos      <= o_pos_next;
            r_lead     <= n_lead;
            r_id       <= n_id;
            r_id_stop  <= n_id_stop;
            r_len_char <= n_len_char;
            r_data     <= n_data;
            r_marks    <= n_marks;
            r_status   <= n_status;
        end
    end

endmodule

[rtl/core/slcan_lrp_classify.sv]
// Line completion detect and classification into one result.
module slcan_lrp_classify
    import slcan_lrp_pkg::*;
#(
    parameter int LINE_BUFFER = 100,
    parameter int POS_W       = 7
) (
    input  t_line_snap       i_snap,
    input  logic [POS_W-1:0] i_pos,    // line length including this byte
    input  logic [7:0]       i_byte,
    output logic             o_emit,
    output t_result          o_result
);

    localparam logic [CMP_W-1:0] OVF_LEN = CMP_W'(LINE_BUFFER - 1);

    logic [CMP_W-1:0] len;
    logic [CMP_W-1:0] need;
    logic [3:0]       dlc;
    logic             term;
    logic             ovf;
    logic             dlc_ok;
    logic             frame_ok;
    logic [7:0]       dlc_diff;

    assign len      = CMP_W'(i_pos);
    assign term     = (i_byte == CH_CR) || (i_byte == CH_BELL);
    assign ovf      = (len >= OVF_LEN);
    assign o_emit   = ovf || term;

    assign dlc_ok   = (i_snap.length_char >= CH_0) && (i_snap.length_char <= CH_8);
    assign dlc_diff = i_snap.length_char - CH_0;
    assign dlc      = dlc_ok ? dlc_diff[3:0] : 4'd0;
    assign need     = POS_DATA + CMP_W'({dlc, 1'b0});
    assign frame_ok = dlc_ok && (len >= POS_DATA) && (len >= need);

    always_comb begin
        o_result = '0;
        if (ovf) begin
            o_result.line_kind = KIND_OVERFLOW;
        end else begin
            case (i_snap.lead_char)
                CH_T: begin
                    if (frame_ok) begin
                        o_result.line_kind      = KIND_FRAME;
                        o_result.priority_res   = i_snap.id_accum[28:26];
                        o_result.data_page      = i_snap.id_accum[24];
                        o_result.pdu_format     = i_snap.id_accum[23:16];
                        o_result.pdu_specific   = i_snap.id_accum[15:8];
                        o_result.source_address = i_snap.id_accum[7:0];
                        o_result.data_length    = dlc;
                        for (int i = 0; i < DATA_BYTES; i++) begin
                            if (4'(i) < dlc) begin
                                o_result.payload[i*8 +: 8] = i_snap.data_accum[i*8 +: 8];
                            end
                        end
                    end else begin
                        o_result.line_kind = KIND_MALFORMED;
                    end
                end
                CH_F: begin
                    o_result.line_kind = KIND_STATUS;
                    if (len >= STATUS_MIN_LEN) begin
                        o_result.status_code = i_snap.status_accum;
                    end
                end
                CH_CR:   o_result.line_kind = KIND_ACK;
                CH_Z:    o_result.line_kind = KIND_ZREPLY;
                CH_BELL: o_result.line_kind = KIND_BELL_ERR;
                default: o_result.line_kind = KIND_OTHER;
            endcase
        end
    end

endmodule

[rtl/core/slcan_line_receive_parser_unit.sv]
// Top level of the slcan line receive parser: input register, line decode, result register.
//
//  channel  | dir | beat carries                     | tdata / tuser layout
//  ---------+-----+----------------------------------+-----------------------------------
//  s stream | in  | one received serial byte         | tdata[7:0] rx_byte
//  m stream | out | one classified line              | tuser[2:0] line_kind, tdata below
//
//  Throughput: one byte per clock while the result register is not stalled. A
//  byte is held in the input register, is decoded against the line state and
//  lands in the result register once that register is empty or draining; the
//  result is then valid until the receiver takes it.
//  Reset (i_rst_n low, synchronous) empties both registers and clears the line.
//  A stalled result holds the pipe; the input side still takes a beat while the
//  input register is empty or moving on.
module slcan_line_receive_parser_unit
    import slcan_lrp_pkg::*;
#(
    parameter int LINE_BUFFER = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,   // [7:0] rx_byte
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    // [2:0] priority_res, [3] data_page, [11:4] pdu_format, [19:12] pdu_specific,
    // [27:20] source_address, [31:28] data_length, [95:32] payload,
    // [102:96] status_code, [103] zero
    output logic [TDATA_W-1:0] o_m_tdata,
    output logic [2:0]         o_m_tuser    // [2:0] line_kind
);

    // line length never exceeds LINE_BUFFER-1, so this holds every position
    localparam int POS_W = $clog2(LINE_BUFFER);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_out_valid;
    t_result          r_out;

    logic             out_ready;
    logic             proc;
    logic             take;
    logic             emit;
    t_line_snap       snap;
    logic [POS_W-1:0] pos_next;
    t_result          result;

    // result register frees up when empty or drained this cycle
    assign out_ready  = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && out_ready;
    // NUL bytes are dropped without touching the line
    assign take       = proc && (r_in_byte != CH_NUL);
    assign o_s_tready = !r_in_valid || out_ready;

    slcan_lrp_line_state #(
        .POS_W (POS_W)
    ) u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_clear    (emit),
        .i_byte     (r_in_byte),
        .o_snap     (snap),
        .o_pos_next (pos_next)
    );

    slcan_lrp_classify #(
        .LINE_BUFFER (LINE_BUFFER),
        .POS_W       (POS_W)
    ) u_classify (
        .i_snap   (snap),
        .i_pos    (pos_next),
        .i_byte   (r_in_byte),
        .o_emit   (emit),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= take && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.line_kind;
    assign o_m_tdata  = {1'b0,
                         r_out.status_code,
                         r_out.payload,
                         r_out.data_length,
                         r_out.source_address,
                         r_out.pdu_specific,
                         r_out.pdu_format,
                         r_out.data_page,
                         r_out.priority_res};

endmodule

[tb/slcan_line_receive_parser_unit_tb.sv]
// Self-checking testbench for the slcan line receive parser: directed lines, then random traffic.
module slcan_line_receive_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcan_lrp_pkg::*;

    localparam int LINE_BUF    = 100;
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off, fills the pipe
    localparam int PHASE_BYTES = 160;   // random bytes per idling phase

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [7:0]          i_s_tdata  = '0;   // [7:0] rx_byte
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    // [2:0] priority_res, [3] data_page, [11:4] pdu_format, [19:12] pdu_specific,
    // [27:20] source_address, [31:28] data_length, [95:32] payload,
    // [102:96] status_code, [103] zero
    logic [TDATA_W-1:0]  o_m_tdata;
    logic [2:0]          o_m_tuser;         // [2:0] line_kind

    slcan_line_receive_parser_unit #(
        .LINE_BUFFER(LINE_BUF)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Line decoder shadow: state of the line being gathered
    // ------------------------------------------------------------------
    int unsigned  line_pos;
    logic [7:0]   lead_byte;
    logic [31:0]  id_acc;
    logic         id_halt;
    logic [7:0]   dlc_char;
    logic [63:0]  data_acc;
    logic [7:0]   data_halt;     // one stop flag per data byte
    logic [6:0]   status_acc;

    t_result      parsed_due[$]; // decoded lines still to come out of the block
    int           fail_count = 0;
    int           rx_bytes_sent = 0;

    int           gap_pct = 0;   // sender idle chance, percent
    int           stall_pct = 0; // receiver stall chance, percent
    int           hold_req = 0;  // bumped by the sender side to ask for a long hold

    function automatic void clear_line_state();
        line_pos   = 0;
        lead_byte  = '0;
        id_acc     = '0;
        id_halt    = 1'b0;
        dlc_char   = '0;
        data_acc   = '0;
        data_halt  = '0;
        status_acc = '0;
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    // Folds one byte into the line; returns 1 when the byte completes a line.
    function automatic bit parse_byte(input logic [7:0] b, output t_result res);
        int           v;
        int           k;
        logic [7:0]   cur;
        logic [7:0]   d;
        int unsigned  dlc;
        bit           ok;
        logic [63:0]  mask;
        res = '0;
        if (b == CH_NUL) return 1'b0;
        v = hex_digit(b);
        if (line_pos == POS_LEAD) begin
            lead_byte = b;
        end else if (line_pos <= POS_ID_LAST) begin
            // hex field stops at its first non-hex char
            if (!id_halt && v >= 0) id_acc = {id_acc[27:0], v[3:0]};
            else id_halt = 1'b1;
        end else if (line_pos == POS_DLC) begin
            dlc_char = b;
        end else if (line_pos < POS_DATA_END) begin
            k = int'(line_pos - POS_DATA) >> 1;
            if (!data_halt[k] && v >= 0) begin
                cur = data_acc[8*k +: 8];
                data_acc[8*k +: 8] = {cur[3:0], v[3:0]};
            end else begin
                data_halt[k] = 1'b1;
            end
        end
        if (line_pos == POS_STATUS_HI || line_pos == POS_STATUS_LO) begin
            d = (b >= CH_0 && b <= CH_9) ? b - CH_0 : 8'd0;
            status_acc = (line_pos == POS_STATUS_HI) ? d[6:0] : status_acc * 7'd10 + d[6:0];
        end
        line_pos++;

        if (line_pos >= LINE_BUF - 1) begin
            res.line_kind = KIND_OVERFLOW;
            clear_line_state();
            return 1'b1;
        end
        if (b != CH_CR && b != CH_BELL) return 1'b0;

        if (lead_byte == CH_T) begin
            ok  = line_pos >= POS_DATA && dlc_char >= CH_0 && dlc_char <= CH_8;
            dlc = ok ? int'(dlc_char - CH_0) : 0;
            if (ok && line_pos < POS_DATA + 2 * dlc) ok = 1'b0;
            if (ok) begin
                mask = (dlc >= 8) ? '1 : (64'd1 << (dlc * 8)) - 64'd1;
                res.line_kind      = KIND_FRAME;
                res.priority_res   = id_acc[28:26];
                res.data_page      = id_acc[24];
                res.pdu_format     = id_acc[23:16];
                res.pdu_specific   = id_acc[15:8];
                res.source_address = id_acc[7:0];
                res.data_length    = dlc[3:0];
                res.payload        = data_acc & mask;
            end else begin
                res.line_kind = KIND_MALFORMED;
            end
        end else if (lead_byte == CH_F) begin
            res.line_kind   = KIND_STATUS;
            res.status_code = (line_pos >= STATUS_MIN_LEN) ? status_acc : 7'd0;
        end else if (lead_byte == CH_CR) begin
            res.line_kind = KIND_ACK;
        end else if (lead_byte == CH_Z) begin
            res.line_kind = KIND_ZREPLY;
        end else if (lead_byte == CH_BELL) begin
            res.line_kind = KIND_BELL_ERR;
        end else begin
            res.line_kind = KIND_OTHER;
        end
        clear_line_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offers one byte, waits for the beat, then records what it should produce.
    // A typed row substitutes its hand-written result for the decoded one.
    task automatic send_rx_byte(input logic [7:0] b, input bit use_typed,
                                input t_result typed);
        t_result res;
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        do @(posedge i_clk); while (!o_s_tready);
        if (b != CH_NUL) rx_bytes_sent++;
        if (parse_byte(b, res)) parsed_due.push_back(use_typed ? typed : res);
    endtask

    function automatic logic [7:0] rand_hex();
        int v;
        v = $urandom_range(15);
        if (v < 10) return CH_0 + 8'(v);
        return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(v - 10);
    endfunction

    // any byte that neither ends a line nor gets dropped
    function automatic logic [7:0] rand_body_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (b == CH_CR || b == CH_BELL);
        return b;
    endfunction

    // About half well-formed frames with random content; the rest is broken frames,
    // status lines, short replies, junk lines, stray bytes and the odd overlong line.
    task automatic send_random_line();
        logic [7:0] q[$];
        int         pick;
        int         dlc;
        int         cut;
        int         n;
        pick = $urandom_range(99);
        if (pick < 65) begin
            q.push_back(CH_T);
            repeat (8) q.push_back(rand_hex());
            dlc = $urandom_range(8);
            q.push_back(CH_0 + 8'(dlc));
            repeat (2 * dlc) q.push_back(rand_hex());
            if ($urandom_range(9) == 0) repeat ($urandom_range(1, 4)) q.push_back(rand_hex());
            q.push_back($urandom_range(7) == 0 ? CH_BELL : CH_CR);
            if (pick >= 50) begin
                if ($urandom_range(1)) begin
                    q[$urandom_range(1, q.size() - 2)] = 8'($urandom_range(1, 255));
                end else begin
                    cut = $urandom_range(1, q.size() - 1);
                    q = q[0:cut-1];
                    q.push_back(CH_CR);
                end
            end
        end else if (pick < 75) begin
            q.push_back(CH_F);
            n = $urandom_range(3);
            repeat (n) q.push_back($urandom_range(3) ? CH_0 + 8'($urandom_range(9))
                                                     : rand_body_byte());
            q.push_back(CH_CR);
        end else if (pick < 85) begin
            case ($urandom_range(2))
                0: q.push_back(CH_CR);
                1: begin
                    q.push_back(CH_Z);
                    q.push_back(CH_CR);
                end
                default: q.push_back(CH_BELL);
            endcase
        end else if (pick < 96) begin
            repeat ($urandom_range(1, 13)) q.push_back(rand_body_byte());
            q.push_back($urandom_range(3) == 0 ? CH_BELL : CH_CR);
        end else if (pick < 98) begin
            q.push_back(8'($urandom_range(255)));
        end else begin
            repeat (LINE_BUF - 2) q.push_back(rand_body_byte());
            q.push_back(8'($urandom_range(1, 255)));
        end
        foreach (q[i]) begin
            if ($urandom_range(49) == 0) send_rx_byte(CH_NUL, 1'b0, '0);
            send_rx_byte(q[i], 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, a long hold on request, result checks
    // ------------------------------------------------------------------
    task automatic check_line(input logic [TDATA_W-1:0] tdata, input logic [2:0] tuser);
        t_result     want;
        logic [63:0] w [10];
        logic [63:0] g [10];
        string       field [10];
        field = '{"line_kind", "priority_res", "data_page", "pdu_format", "pdu_specific",
                  "source_address", "data_length", "payload", "status_code", "pad"};
        if (parsed_due.size() == 0) begin
            $display("%0t: unexpected line result, kind %0d tdata %h", $time, tuser, tdata);
            fail_count++;
            return;
        end
        want = parsed_due.pop_front();
        w = '{64'(want.line_kind), 64'(want.priority_res), 64'(want.data_page),
              64'(want.pdu_format), 64'(want.pdu_specific), 64'(want.source_address),
              64'(want.data_length), want.payload, 64'(want.status_code), 64'd0};
        g = '{64'(tuser), 64'(tdata[2:0]), 64'(tdata[3]), 64'(tdata[11:4]),
              64'(tdata[19:12]), 64'(tdata[27:20]), 64'(tdata[31:28]), tdata[95:32],
              64'(tdata[102:96]), 64'(tdata[103])};
        for (int i = 0; i < 10; i++) begin
            if (w[i] !== g[i]) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, field[i], w[i], g[i]);
                fail_count++;
            end
        end
    endtask

    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) check_line(o_m_tdata, o_m_tuser);
            if (hold_req != hold_seen) begin
                hold_seen  <= hold_req;
                hold_left  <= HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left  <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    typedef struct {
        string      text;       // line body
        logic [7:0] term;       // terminator appended, NUL for none
        bit         with_nul;   // a dropped NUL ahead of every body byte
        bit         typed;      // check against want rather than the decoder
        t_result    want;
    } t_stim_row;

    t_stim_row stim_rows[$];

    function automatic void add_row(input string text, input logic [7:0] term,
                                    input bit with_nul, input bit typed, input t_result want);
        t_stim_row row;
        row.text     = text;
        row.term     = term;
        row.with_nul = with_nul;
        row.typed    = typed;
        row.want     = want;
        stim_rows.push_back(row);
    endfunction

    function automatic t_result line_result(
        input t_line_kind kind, input logic [2:0] prio, input logic page,
        input logic [7:0] pf, input logic [7:0] ps, input logic [7:0] sa,
        input logic [3:0] dlc, input logic [63:0] pl, input logic [6:0] sc);
        t_result res;
        res.line_kind      = kind;
        res.priority_res   = prio;
        res.data_page      = page;
        res.pdu_format     = pf;
        res.pdu_specific   = ps;
        res.source_address = sa;
        res.data_length    = dlc;
        res.payload        = pl;
        res.status_code    = sc;
        return res;
    endfunction

    initial begin
        string   long_junk;
        string   long_frame;
        t_result none;
        none       = '0;
        long_junk  = "";
        long_frame = "T";
        repeat (LINE_BUF - 1) long_junk = {long_junk, "x"};
        repeat (LINE_BUF - 3) long_frame = {long_frame, "5"};

        clear_line_state();

        // bare replies, byte extremes
        add_row("", CH_CR, 0, 1, line_result(KIND_ACK, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("", CH_BELL, 0, 1, line_result(KIND_BELL_ERR, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("Z", CH_CR, 0, 1, line_result(KIND_ZREPLY, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("\377", CH_CR, 0, 1, line_result(KIND_OTHER, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("\001", CH_CR, 1, 1, line_result(KIND_OTHER, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("V", CH_CR, 0, 1, line_result(KIND_OTHER, 0, 0, 0, 0, 0, 0, 0, 0));
        // frames: all zero, all ones, lowercase data ended by BELL
        add_row("T000000000", CH_CR, 0, 1, line_result(KIND_FRAME, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("T1FFFFFFF8FFFFFFFFFFFFFFFF", CH_CR, 0, 1,
                line_result(KIND_FRAME, 3'd7, 1'b1, 8'hFF, 8'hFF, 8'hFF, 4'd8, '1, 0));
        add_row("TFFFFFFFF8ffffffffffffffff", CH_BELL, 0, 1,
                line_result(KIND_FRAME, 3'd7, 1'b1, 8'hFF, 8'hFF, 8'hFF, 4'd8, '1, 0));
        // malformed: too short, bad length digit, data too short
        add_row("T1234", CH_CR, 0, 1, line_result(KIND_MALFORMED, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("T123456789", CH_CR, 0, 1,
                line_result(KIND_MALFORMED, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("T123456782AB", CH_CR, 0, 1,
                line_result(KIND_MALFORMED, 0, 0, 0, 0, 0, 0, 0, 0));
        // mixed-case digits with NULs in between; hex fields cut short by junk
        add_row("T18fEaB1c3A1b2C3", CH_CR, 1, 0, none);
        add_row("T12G456782AxBC", CH_CR, 0, 0, none);
        // status: plain, max, no digits, one digit, non-digit
        add_row("F42", CH_CR, 0, 1, line_result(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0, 7'd42));
        add_row("F99", CH_CR, 0, 1, line_result(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0, 7'd99));
        add_row("F", CH_CR, 0, 1, line_result(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row("F7", CH_BELL, 0, 0, none);
        add_row("Fx5", CH_CR, 0, 1, line_result(KIND_STATUS, 0, 0, 0, 0, 0, 0, 0, 7'd5));
        // overflow without a terminator, and with one as the last byte
        add_row(long_junk, CH_NUL, 0, 1, line_result(KIND_OVERFLOW, 0, 0, 0, 0, 0, 0, 0, 0));
        add_row(long_frame, CH_CR, 0, 1, line_result(KIND_OVERFLOW, 0, 0, 0, 0, 0, 0, 0, 0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            for (int i = 0; i < stim_rows[r].text.len(); i++) begin
                if (stim_rows[r].with_nul) send_rx_byte(CH_NUL, 1'b0, none);
                send_rx_byte(stim_rows[r].text[i], stim_rows[r].typed, stim_rows[r].want);
            end
            if (stim_rows[r].term != CH_NUL)
                send_rx_byte(stim_rows[r].term, stim_rows[r].typed, stim_rows[r].want);
        end

        // Random phases: no idling (with the long hold), sender gaps,
        // receiver stalls, both a little.
        for (int ph = 0; ph < 4; ph++) begin
            int target;
            target = rx_bytes_sent + PHASE_BYTES;
            case (ph)
                0: begin gap_pct = 0;  stall_pct <= 0;  hold_req <= hold_req + 1; end
                1: begin gap_pct = 77; stall_pct <= 0;  end
                2: begin gap_pct = 0;  stall_pct <= 77; end
                default: begin gap_pct = 11; stall_pct <= 11; end
            endcase
            while (rx_bytes_sent < target) send_random_line();
        end

        // drain: receiver always ready, wait for every pending line
        i_s_tvalid <= 1'b0;
        stall_pct  <= 0;
        for (int w = 0; w < 2000 && parsed_due.size() != 0; w++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (parsed_due.size() != 0) begin
            $display("%0t: %0d line results never arrived", $time, parsed_due.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
